// ----- hw/rtl/mnps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnps_pkg : shared types and constants for the note priority stack
// Beat payloads, chain command word, field codes and sizes.
// ----------------------------------------------------------------------------
package mnps_pkg;

	localparam int MAX_HELD = 128;
	localparam int KEY_W    = 7;
	localparam int VEL_W    = 7;
	localparam int CHAN_W   = 4;
	localparam int CNT_W    = $clog2(MAX_HELD + 1);
	localparam int CFG_W    = 1;
	localparam int CFG_IDX_W = 1;

	localparam logic KIND_ON  = 1'b0;
	localparam logic KIND_OFF = 1'b1;

	localparam logic [1:0] PA_NONE  = 2'd0;
	localparam logic [1:0] PA_JUMP  = 2'd1;
	localparam logic [1:0] PA_GLIDE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_ALWAYS       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_ON_NOTE_ONLY = CFG_IDX_W'(1);

	typedef struct packed {
		logic              kind;
		logic [KEY_W-1:0]  key;
		logic [VEL_W-1:0]  velocity;
		logic [CHAN_W-1:0] channel;
	} evt_t;

	typedef struct packed {
		logic [KEY_W-1:0]  sounding_note;
		logic [7:0]        held_count;
		logic              new_key;
		logic              attack;
		logic              legato_on;
		logic [1:0]        pitch_action;
		logic              release_res;
		logic              note_return;
		logic              velocity_changed;
		logic [VEL_W-1:0]  last_velocity;
		logic [CHAN_W-1:0] last_channel;
	} res_t;

	// command word walking down the cell row
	typedef struct packed {
		logic              valid;
		logic [CNT_W-1:0]  left;    // occupied cells from here on
		logic              found;
		logic              placed;
		logic [KEY_W-1:0]  last;    // old newest key
		logic [KEY_W-1:0]  penult;  // newest key after a removal
	} cmd_t;

endpackage : mnps_pkg
`default_nettype wire

// ----- hw/rtl/mono_note_priority_stack_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_note_priority_stack_unit : last-note-priority monophonic note stack
// Keeps the ordered held keys in a row of cells and reports one result
// beat per note event.
//
//   channel | dir | handshake           | payload
//   evt     | in  | evt_valid/evt_stall | mnps_pkg::evt_t
//   res     | out | res_valid/res_stall | mnps_pkg::res_t
//   cfg     | in  | cfg_we              | cfg_idx, cfg_data
//
// A result beat passes the start register, the cell registers down the row, the
// pending result register and the output register; the next event is taken
// only after the result of the last one has entered the output register.
// Reset leaves the stack empty and the sounding note, velocity and channel at zero.
// evt_stall is high from accept until the result has entered the output
// register; a stalled result beat holds its payload.
// ----------------------------------------------------------------------------
module mono_note_priority_stack_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           evt_valid,
	output logic                          evt_stall,
	input  mnps_pkg::evt_t                evt,
	output logic                          res_valid,
	input  wire                           res_stall,
	output mnps_pkg::res_t                res,
	input  wire                           cfg_we,
	input  wire [mnps_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [mnps_pkg::CFG_W-1:0]     cfg_data
);
	import mnps_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_RES  = 2'd2;

	logic [1:0]        state_q;
	logic              glide_q;
	logic              pono_q;
	logic [CNT_W-1:0]  total_q;
	logic [KEY_W-1:0]  note_q;
	logic [VEL_W-1:0]  vel_q;
	logic [CHAN_W-1:0] chan_q;
	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic              vchg_q;
	logic              start_q;
	res_t              pend_q;
	res_t              res_q;
	logic              res_valid_q;

	cmd_t              head;
	cmd_t              tail;
	logic              evt_acc;
	logic              out_free;

	res_t              nxt;
	logic [CNT_W-1:0]  nxt_total;
	logic              sounding;

	assign evt_stall = state_q != ST_IDLE;
	assign evt_acc   = evt_valid && !evt_stall;
	assign out_free  = !res_valid_q || !res_stall;

	always_comb begin
		head        = '0;
		head.valid  = start_q;
		head.left   = total_q;
	end

	mnps_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.kind     (kind_q),
		.key      (key_q),
		.cmd_head (head),
		.cmd_tail (tail)
	);

	assign sounding = key_q == note_q;

	always_comb begin
		nxt                  = '0;
		nxt.last_velocity    = vel_q;
		nxt.last_channel     = chan_q;
		nxt.velocity_changed = vchg_q;
		nxt.sounding_note    = note_q;
		if (kind_q == KIND_ON) begin
			nxt_total         = total_q + CNT_W'(tail.placed);
			nxt.new_key       = tail.placed;
			nxt.sounding_note = tail.placed ? key_q : tail.last;
			nxt.attack        = nxt_total == CNT_W'(1);
			nxt.legato_on     = !nxt.attack;
			nxt.pitch_action  = (nxt.attack && !glide_q) ? PA_JUMP : PA_GLIDE;
		end else begin
			nxt_total = total_q - CNT_W'(tail.found);
			if (nxt_total == '0) begin
				nxt.release_res = 1'b1;
			end else if (sounding && !pono_q) begin
				nxt.sounding_note = tail.found ? tail.penult : tail.last;
				nxt.pitch_action  = PA_GLIDE;
				nxt.note_return   = 1'b1;
			end
		end
		nxt.held_count = 8'(nxt_total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glide_q <= 1'b0;
			pono_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GLIDE_ALWAYS:       glide_q <= cfg_data[0];
				CFG_PITCH_ON_NOTE_ONLY: pono_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			total_q     <= '0;
			note_q      <= '0;
			vel_q       <= '0;
			chan_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			start_q     <= evt_acc;
			res_valid_q <= (state_q == ST_RES && out_free) || (res_valid_q && res_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (evt_acc) begin
						state_q <= ST_WALK;
						if (evt.kind == KIND_ON) begin
							chan_q <= evt.channel;
							vel_q  <= evt.velocity;
						end
					end
				end
				ST_WALK: begin
					if (tail.valid) begin
						total_q <= nxt_total;
						note_q  <= nxt.sounding_note;
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			kind_q <= evt.kind;
			key_q  <= evt.key;
			vchg_q <= (evt.kind == KIND_ON) && (evt.velocity != vel_q);
		end
		if (state_q == ST_WALK && tail.valid) begin
			pend_q <= nxt;
		end
		if (state_q == ST_RES && out_free) begin
			res_q <= pend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_tail_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> state_q == ST_WALK)
		else $error("command left the cell row outside a walk");

	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		evt_acc |=> (state_q == ST_WALK && start_q))
		else $error("accepted beat did not start a walk");

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q)
		else $error("walk start longer than one cycle");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_HELD))
		else $error("held count above stack depth");

	a_note_off_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && tail.valid && kind_q == KIND_OFF) |=>
		total_q <= $past(total_q))
		else $error("note off grew the stack");
`endif

endmodule : mono_note_priority_stack_unit
`default_nettype wire

// ----- hw/rtl/mnps_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnps_cell : one stack slot
// Holds one key; matches, appends or shifts as the command passes through.
// ----------------------------------------------------------------------------
module mnps_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      kind,
	input  wire [mnps_pkg::KEY_W-1:0] key,
	input  mnps_pkg::cmd_t           cmd_in,
	input  wire [mnps_pkg::KEY_W-1:0] next_key,
	output logic [mnps_pkg::KEY_W-1:0] key_out,
	output mnps_pkg::cmd_t           cmd_out
);
	import mnps_pkg::*;

	logic [KEY_W-1:0] key_q;
	cmd_t             cmd_q;
	logic             occ;
	logic             hit;
	logic             fnd;
	logic             shift;
	logic             place;
	logic [KEY_W-1:0] new_key;

	assign occ     = cmd_in.left != '0;
	assign hit     = occ && (key_q == key);
	assign fnd     = cmd_in.found | hit;
	assign shift   = cmd_in.valid && (kind == KIND_OFF) && occ && fnd;
	assign place   = cmd_in.valid && (kind == KIND_ON) && !occ && !fnd && !cmd_in.placed;
	assign new_key = fnd ? next_key : key_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= next_key;
		end else if (place) begin
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
		end else begin
			cmd_q.valid  <= cmd_in.valid;
			cmd_q.left   <= occ ? cmd_in.left - CNT_W'(1) : '0;
			cmd_q.found  <= fnd;
			cmd_q.placed <= cmd_in.placed | place;
			cmd_q.last   <= (cmd_in.left == CNT_W'(1)) ? key_q : cmd_in.last;
			cmd_q.penult <= (cmd_in.left == CNT_W'(2)) ? new_key : cmd_in.penult;
		end
	end

	assign key_out = key_q;
	assign cmd_out = cmd_q;

endmodule : mnps_cell
`default_nettype wire

// ----- hw/rtl/mnps_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnps_chain : row of stack cells
// Oldest key in cell 0; the command moves one cell per cycle.
// ----------------------------------------------------------------------------
module mnps_chain (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      kind,
	input  wire [mnps_pkg::KEY_W-1:0] key,
	input  mnps_pkg::cmd_t           cmd_head,
	output mnps_pkg::cmd_t           cmd_tail
);
	import mnps_pkg::*;

	cmd_t             link [MAX_HELD+1];
	logic [KEY_W-1:0] slot [MAX_HELD+1];

	assign link[0]        = cmd_head;
	assign slot[MAX_HELD] = '0;

	for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
		mnps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.kind     (kind),
			.key      (key),
			.cmd_in   (link[i]),
			.next_key (slot[i+1]),
			.key_out  (slot[i]),
			.cmd_out  (link[i+1])
		);
	end

	assign cmd_tail = link[MAX_HELD];

endmodule : mnps_chain
`default_nettype wire

// ----- verif/tb_mono_note_priority_stack_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_note_priority_stack_unit : self-checking bench for the note stack
// A short table of note events covers empty-stack releases, extreme keys,
// velocities and channels, repeated keys and returns to held keys. Random
// phases follow: small key pools, full-stack fills and drains, and raw noise.
// Every result beat is checked field by field against an in-bench model of
// the held-key stack or a fixed table result, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_mono_note_priority_stack_unit;
	import mnps_pkg::*;

	localparam int RAND_ITEMS = 1350;
	localparam int LIMIT_CYC  = 1500000;
	localparam int HOLD_CYC   = 2000;
	localparam int LAT_CYC    = MAX_HELD + 12;

	typedef struct {
		logic glide;
		logic ponly;
		evt_t e;
		bit   fixed;
		res_t want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 evt_valid;
	logic                 evt_stall;
	evt_t                 evt;
	logic                 res_valid;
	logic                 res_stall;
	res_t                 res;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	// model of the held-key stack, oldest first
	logic [KEY_W-1:0]  pk_stack [MAX_HELD];
	int                pk_count = 0;
	logic [KEY_W-1:0]  pk_note  = '0;
	logic [VEL_W-1:0]  pk_vel   = '0;
	logic [CHAN_W-1:0] pk_chan  = '0;
	logic              pk_glide = 1'b0;
	logic              pk_ponly = 1'b0;

	res_t due_res[$];
	row_t rows[$];
	int   errors = 0;
	int   cycles = 0;
	bit   idle_on;
	bit   hold_req;

	mono_note_priority_stack_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYC) begin
			$display("FAIL mono_note_priority_stack_unit");
			$finish;
		end
	end

	function automatic res_t mk_res(input logic [KEY_W-1:0] note, input logic [7:0] cnt,
			input logic nk, input logic att, input logic leg, input logic [1:0] pa,
			input logic rel, input logic ret, input logic vc,
			input logic [VEL_W-1:0] lv, input logic [CHAN_W-1:0] lc);
		res_t r;
		r.sounding_note    = note;
		r.held_count       = cnt;
		r.new_key          = nk;
		r.attack           = att;
		r.legato_on        = leg;
		r.pitch_action     = pa;
		r.release_res      = rel;
		r.note_return      = ret;
		r.velocity_changed = vc;
		r.last_velocity    = lv;
		r.last_channel     = lc;
		return r;
	endfunction

	function automatic res_t predict_note(input evt_t e);
		res_t r;
		int   pos;
		int   i;
		logic was_sounding;
		r = '0;
		pos = -1;
		for (i = 0; i < pk_count; i++)
			if (pos < 0 && pk_stack[i] == e.key)
				pos = i;
		if (e.kind == KIND_ON) begin
			pk_chan = e.channel;
			if (pk_vel != e.velocity) begin
				pk_vel = e.velocity;
				r.velocity_changed = 1'b1;
			end
			if (pos < 0 && pk_count < MAX_HELD) begin
				pk_stack[pk_count] = e.key;
				pk_count++;
				r.new_key = 1'b1;
			end
			if (pk_count > 0)
				pk_note = pk_stack[pk_count-1];
			if (pk_count == 1) begin
				r.attack = 1'b1;
				r.pitch_action = pk_glide ? PA_GLIDE : PA_JUMP;
			end else begin
				r.legato_on = 1'b1;
				r.pitch_action = PA_GLIDE;
			end
		end else begin
			was_sounding = (e.key == pk_note);
			if (pos >= 0) begin
				for (i = pos; i + 1 < pk_count; i++)
					pk_stack[i] = pk_stack[i+1];
				pk_count--;
			end
			if (pk_count == 0) begin
				r.release_res = 1'b1;
			end else if (was_sounding && !pk_ponly) begin
				pk_note = pk_stack[pk_count-1];
				r.pitch_action = PA_GLIDE;
				r.note_return = 1'b1;
			end
		end
		r.sounding_note = pk_note;
		r.held_count    = 8'(pk_count);
		r.last_velocity = pk_vel;
		r.last_channel  = pk_chan;
		return r;
	endfunction

	// mostly a key that is held, so note-offs actually shrink the stack
	function automatic logic [KEY_W-1:0] pick_off_key(input logic [KEY_W-1:0] other);
		if (pk_count > 0 && $urandom_range(0, 99) < 75)
			return pk_stack[$urandom_range(0, pk_count - 1)];
		return other;
	endfunction

	function automatic logic [VEL_W-1:0] pick_vel();
		if ($urandom_range(0, 3) == 0)
			return pk_vel;
		return VEL_W'($urandom_range(0, 127));
	endfunction

	task automatic put_row(input logic g, input logic p, input logic kind,
			input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] vel,
			input logic [CHAN_W-1:0] chan, input bit fixed, input res_t want);
		row_t rw;
		rw.glide      = g;
		rw.ponly      = p;
		rw.e.kind     = kind;
		rw.e.key      = key;
		rw.e.velocity = vel;
		rw.e.channel  = chan;
		rw.fixed      = fixed;
		rw.want       = want;
		rows = {rows, rw};
	endtask

	task automatic send_note(input evt_t e, input bit fixed, input res_t want);
		int   gap;
		res_t r;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt       <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (evt_stall);
		r = predict_note(e);
		if (fixed)
			r = want;
		due_res = {due_res, r};
	endtask

	task automatic settle();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (due_res.size() > 0) @(posedge clk);
	endtask

	task automatic set_regs(input logic g, input logic p);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_GLIDE_ALWAYS;
		cfg_data <= g;
		@(posedge clk);
		cfg_idx  <= CFG_PITCH_ON_NOTE_ONLY;
		cfg_data <= p;
		@(posedge clk);
		cfg_we   <= 1'b0;
		pk_glide = g;
		pk_ponly = p;
	endtask

	task automatic send_mixed(input int n, input int w);
		evt_t e;
		int   base;
		int   k;
		base = $urandom_range(0, 127);
		for (k = 0; k < n; k++) begin
			e.kind     = ($urandom_range(0, 99) < 55) ? KIND_ON : KIND_OFF;
			e.key      = KEY_W'(base + $urandom_range(0, w - 1));
			if (e.kind == KIND_OFF)
				e.key = pick_off_key(e.key);
			e.velocity = pick_vel();
			e.channel  = CHAN_W'($urandom_range(0, 15));
			send_note(e, 1'b0, '0);
		end
	endtask

	task automatic cmp_field(input string nm, input int e, input int a);
		if (e != a) begin
			errors++;
			$display("%0t ns: %s expected %0d got %0d", $time, nm, e, a);
		end
	endtask

	initial begin : res_side
		res_t want;
		int   gap;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
			end
			gap = idle_on ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			if (due_res.size() == 0) begin
				errors++;
				$display("%0t ns: result beat expected none got %p", $time, res);
			end else begin
				want = due_res.pop_front();
				cmp_field("sounding_note", want.sounding_note, res.sounding_note);
				cmp_field("held_count", want.held_count, res.held_count);
				cmp_field("new_key", want.new_key, res.new_key);
				cmp_field("attack", want.attack, res.attack);
				cmp_field("legato_on", want.legato_on, res.legato_on);
				cmp_field("pitch_action", want.pitch_action, res.pitch_action);
				cmp_field("release_res", want.release_res, res.release_res);
				cmp_field("note_return", want.note_return, res.note_return);
				cmp_field("velocity_changed", want.velocity_changed, res.velocity_changed);
				cmp_field("last_velocity", want.last_velocity, res.last_velocity);
				cmp_field("last_channel", want.last_channel, res.last_channel);
			end
		end
	end

	initial begin : evt_side
		evt_t e;
		int   ph;
		int   mode;
		int   n;
		int   start;
		int   stride;
		int   sent;
		arst_n    = 1'b0;
		evt_valid = 1'b0;
		evt       = '0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_data  = '0;
		idle_on   = 1'b1;
		hold_req  = 1'b0;

		// empty stack, extremes, held keys, returns and releases
		put_row(0, 0, KIND_OFF, 0, 0, 0, 1,
			mk_res(0, 0, 0, 0, 0, PA_NONE, 1, 0, 0, 0, 0));
		put_row(0, 0, KIND_ON, 127, 127, 15, 1,
			mk_res(127, 1, 1, 1, 0, PA_JUMP, 0, 0, 1, 127, 15));
		put_row(0, 0, KIND_ON, 127, 127, 0, 1,
			mk_res(127, 1, 0, 1, 0, PA_JUMP, 0, 0, 0, 127, 0));
		put_row(0, 0, KIND_ON, 0, 0, 15, 1,
			mk_res(0, 2, 1, 0, 1, PA_GLIDE, 0, 0, 1, 0, 15));
		put_row(0, 0, KIND_ON, 64, 1, 5, 0, '0);
		put_row(0, 0, KIND_ON, 0, 1, 5, 0, '0);
		put_row(0, 0, KIND_OFF, 3, 0, 0, 0, '0);
		put_row(0, 0, KIND_OFF, 0, 0, 0, 0, '0);
		put_row(0, 0, KIND_OFF, 64, 0, 0, 0, '0);
		put_row(0, 0, KIND_ON, 42, 100, 9, 0, '0);
		put_row(0, 0, KIND_OFF, 127, 0, 0, 0, '0);
		put_row(0, 0, KIND_OFF, 42, 0, 0, 0, '0);
		put_row(0, 0, KIND_OFF, 42, 0, 0, 0, '0);
		put_row(0, 0, KIND_ON, 7'h55, 7'h2a, 4'ha, 0, '0);
		put_row(0, 0, KIND_ON, 7'h2a, 7'h55, 4'h5, 0, '0);
		put_row(0, 0, KIND_OFF, 7'h55, 7'h7f, 4'hf, 0, '0);
		put_row(0, 0, KIND_OFF, 7'h2a, 0, 0, 0, '0);
		put_row(1, 1, KIND_ON, 30, 20, 3, 1,
			mk_res(30, 1, 1, 1, 0, PA_GLIDE, 0, 0, 1, 20, 3));
		put_row(1, 1, KIND_ON, 31, 20, 3, 0, '0);
		put_row(1, 1, KIND_OFF, 31, 0, 0, 0, '0);
		// sounding key no longer held: note-off still returns to the newest
		put_row(1, 0, KIND_OFF, 31, 0, 0, 0, '0);
		put_row(1, 0, KIND_OFF, 30, 0, 0, 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs(1'b0, 1'b0);
		foreach (rows[i]) begin
			if (rows[i].glide !== pk_glide || rows[i].ponly !== pk_ponly) begin
				settle();
				set_regs(rows[i].glide, rows[i].ponly);
			end
			send_note(rows[i].e, rows[i].fixed, rows[i].want);
		end

		sent = 0;
		for (ph = 0; sent < RAND_ITEMS; ph++) begin
			settle();
			set_regs(ph[0] ^ ph[2], ph[1]);
			mode = ph % 4;
			idle_on = (mode != 2);
			if (ph == 0)
				hold_req = 1'b1;
			case (mode)
				0: begin
					send_mixed(150, $urandom_range(1, 16));
					sent += 150;
				end
				1: begin
					// walk every key once, then a few repeats on a full stack, then note-offs
					start  = $urandom_range(0, 127);
					stride = 2 * $urandom_range(0, 63) + 1;
					for (n = 0; n < MAX_HELD + 8; n++) begin
						e.kind     = KIND_ON;
						e.key      = KEY_W'(start + n * stride);
						e.velocity = pick_vel();
						e.channel  = CHAN_W'($urandom_range(0, 15));
						send_note(e, 1'b0, '0);
					end
					for (n = 0; n < 170; n++) begin
						e.kind     = KIND_OFF;
						e.key      = pick_off_key(KEY_W'($urandom));
						e.velocity = VEL_W'($urandom);
						e.channel  = CHAN_W'($urandom);
						send_note(e, 1'b0, '0);
					end
					sent += MAX_HELD + 178;
				end
				2: begin
					for (n = 0; n < 80; n++) begin
						e = evt_t'($bits(evt_t)'($urandom));
						send_note(e, 1'b0, '0);
					end
					sent += 80;
				end
				default: begin
					send_mixed(150, $urandom_range(8, 48));
					sent += 150;
				end
			endcase
		end

		settle();
		repeat (LAT_CYC) @(posedge clk);
		if (errors == 0 && due_res.size() == 0) begin
			$display("PASS mono_note_priority_stack_unit");
		end else begin
			$display("FAIL mono_note_priority_stack_unit");
		end
		$finish;
	end

endmodule
